>>> rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator files.
// ----------------------------------------------------------------------------
package ffha_pkg;

	// Width of the request size, address and data offset fields.
	localparam int OFFSET_W = 11;
	// Width of a rounded request size (a request of 2047 rounds up to 2048).
	localparam int SIZE_W   = 12;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_MEMORY = 2'd1,
		ST_FREE_DONE = 2'd2
	} status_t;

	// One command beat.
	typedef struct packed {
		command_t              command;
		logic [OFFSET_W-1:0]   request_size;
		logic [OFFSET_W-1:0]   address;
		logic                  is_null;
	} cmd_beat_t;

	// One response beat.
	typedef struct packed {
		status_t               status;
		logic [OFFSET_W-1:0]   data_offset;
	} rsp_beat_t;

	// Compare results of the shared step unit.
	typedef struct packed {
		logic over_heap;   // base + header + addend runs past the heap end
		logic below_limit; // base + header + addend is below the limit
	} step_flags_t;

endpackage

>>> rtl/ffha_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ffha_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/ffha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> rtl/ffha_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_step_unit
// Shared pointer adder: header end, next block pointer and bound compares.
// ----------------------------------------------------------------------------
module ffha_step_unit #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 16,
	parameter int PTR_W        = 11,
	parameter int ADD_W        = 12,
	parameter int SUM_W        = 14
) (
	input  logic [PTR_W-1:0]     base,
	input  logic [ADD_W-1:0]     addend,
	input  logic [PTR_W-1:0]     limit,
	output logic [SUM_W-1:0]     hdr_end,
	output logic [SUM_W-1:0]     next_ptr,
	output ffha_pkg::step_flags_t flags
);
	// The data area starts one header past the block start; the next block
	// follows the data area.
	always_comb begin
		hdr_end           = SUM_W'(base) + SUM_W'(HEADER_BYTES);
		next_ptr          = hdr_end + SUM_W'(addend);
		flags.over_heap   = next_ptr > SUM_W'(HEAP_BYTES);
		flags.below_limit = next_ptr < SUM_W'(limit);
	end
endmodule

>>> rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocate/free over a fixed heap with a header per block.
// ----------------------------------------------------------------------------
// Each command beat is an allocate or a free and yields exactly one response
// beat. The block handles one command at a time: it takes the beat, walks
// the block headers (one read of the block store per header, with the next
// header address formed by the shared step adder), bump-allocates when an
// allocate finds no free block that fits, and loads the response register.
// At most HEAP_BYTES / HEADER_BYTES headers are walked; a null free, or a
// free while the heap is empty, walks none. While the previous response
// beat is still waiting to be taken, the block holds before loading the
// response register and the command side stays not ready. The block store
// needs no clearing after reset; only headers written by a bump allocation
// are ever read.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ffha_stream_if.sink   cmd,
	ffha_stream_if.source rsp
);
	localparam int STORE_DEPTH = HEAP_BYTES / 8;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int PTR_W       = $clog2(HEAP_BYTES + 1);
	localparam int SZ8_W       = $clog2(STORE_DEPTH + 1);
	localparam int ENTRY_W     = SZ8_W + 1;
	localparam int ADD_W       = (PTR_W > ffha_pkg::SIZE_W) ? PTR_W : ffha_pkg::SIZE_W;
	localparam int SUM_W       = ADD_W + 2;
	localparam int OFF_W       = ffha_pkg::OFFSET_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_BUMP = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t              state_q;
	logic                op_free_q;
	logic [ADD_W-1:0]    size_q;
	logic [OFF_W-1:0]    addr_q;
	logic [PTR_W-1:0]    b_q;
	logic [PTR_W-1:0]    end_q;
	ffha_pkg::status_t   res_status_q;
	logic [OFF_W-1:0]    res_offset_q;
	logic                rsp_valid_q;
	ffha_pkg::rsp_beat_t rsp_beat_q;

	logic                cmd_take;
	logic                rsp_free;
	logic [ffha_pkg::SIZE_W-1:0] rounded;
	logic                rd_en;
	logic [SLOT_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0]  rd_data;
	logic                rd_is_free;
	logic [SZ8_W-1:0]    rd_size8;
	logic [ADD_W-1:0]    blk_bytes;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic [PTR_W-1:0]    step_base;
	logic [ADD_W-1:0]    step_addend;
	logic [SUM_W-1:0]    hdr_end;
	logic [SUM_W-1:0]    next_ptr;
	ffha_pkg::step_flags_t step_flags;
	logic                hit_alloc;
	logic                hit_free;

	// Handshake on both channels.
	assign cmd.ready   = (state_q == S_IDLE);
	assign cmd_take    = cmd.valid && (state_q == S_IDLE);
	assign rsp_free    = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_beat_q;

	// Request size rounded up to a multiple of eight bytes.
	assign rounded = ({1'b0, cmd.payload.request_size} + ffha_pkg::SIZE_W'(7))
		& ~ffha_pkg::SIZE_W'(7);

	// Unpacked store entry of the header being walked.
	assign rd_is_free = rd_data[ENTRY_W-1];
	assign rd_size8   = rd_data[SZ8_W-1:0];
	assign blk_bytes  = ADD_W'({rd_size8, 3'b000});

	// Shared step adder operands: the walk pointer or the end pointer.
	assign step_base   = (state_q == S_BUMP) ? end_q : b_q;
	assign step_addend = (state_q == S_BUMP) ? size_q : blk_bytes;

	ffha_step_unit #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.PTR_W        (PTR_W),
		.ADD_W        (ADD_W),
		.SUM_W        (SUM_W)
	) u_step (
		.base     (step_base),
		.addend   (step_addend),
		.limit    (end_q),
		.hdr_end  (hdr_end),
		.next_ptr (next_ptr),
		.flags    (step_flags)
	);

	// Match decisions for the header being walked.
	assign hit_alloc = !op_free_q && rd_is_free && (blk_bytes >= size_q);
	assign hit_free  = op_free_q && (hdr_end == SUM_W'(addr_q));

	// Store read: slot 0 on a new command, the next header while walking.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == S_WALK) begin
			rd_en   = 1'b1;
			rd_addr = next_ptr[SLOT_W+2:3];
		end else if (cmd_take) begin
			rd_en   = 1'b1;
		end
	end

	// Store write: mark a walked block, or lay down a bumped header.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = b_q[SLOT_W+2:3];
		wr_data = {hit_free, rd_size8};
		if (state_q == S_WALK) begin
			wr_en = hit_alloc || hit_free;
		end else if (state_q == S_BUMP) begin
			wr_en   = !step_flags.over_heap;
			wr_addr = end_q[SLOT_W+2:3];
			wr_data = {1'b0, SZ8_W'(size_q >> 3)};
		end
	end

	ffha_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			end_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						if (cmd.payload.command == ffha_pkg::CMD_FREE) begin
							if (cmd.payload.is_null || (end_q == '0)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_WALK;
							end
						end else if (end_q == '0) begin
							state_q <= S_BUMP;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (hit_alloc || hit_free) begin
						state_q <= S_DONE;
					end else if (!step_flags.below_limit) begin
						state_q <= op_free_q ? S_DONE : S_BUMP;
					end
				end
				S_BUMP: begin
					if (!step_flags.over_heap) begin
						end_q <= next_ptr[PTR_W-1:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command fields, walk pointer and pending result.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_free_q    <= (cmd.payload.command == ffha_pkg::CMD_FREE);
			size_q       <= ADD_W'(rounded);
			addr_q       <= cmd.payload.address;
			b_q          <= '0;
			res_status_q <= (cmd.payload.command == ffha_pkg::CMD_FREE)
				? ffha_pkg::ST_FREE_DONE : ffha_pkg::ST_ALLOCATED;
			res_offset_q <= '0;
		end
		if (state_q == S_WALK) begin
			b_q <= next_ptr[PTR_W-1:0];
			if (hit_alloc) begin
				res_offset_q <= hdr_end[OFF_W-1:0];
			end
		end
		if (state_q == S_BUMP) begin
			if (step_flags.over_heap) begin
				res_status_q <= ffha_pkg::ST_NO_MEMORY;
			end else begin
				res_offset_q <= hdr_end[OFF_W-1:0];
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if ((state_q == S_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_beat_q.status      <= res_status_q;
			rsp_beat_q.data_offset <= res_offset_q;
		end
	end
endmodule
